/* design/spt_pkg.sv */
// ----------------------------------------------------------------------------
// spt_pkg
// Shared types and constants for the serial pattern trigger.
// ----------------------------------------------------------------------------
package spt_pkg;

  localparam int unsigned MAX_PATTERN_DEF = 8;
  localparam int unsigned PAT_BYTES       = 8;
  localparam int unsigned LEN_W           = 4;
  localparam int unsigned TICK_W          = 16;
  localparam int unsigned IDX_W           = 8;

  localparam logic [TICK_W-1:0] PULSE_RESET = TICK_W'(200);

  // command codes
  localparam logic [1:0] CMD_BYTE   = 2'd0;
  localparam logic [1:0] CMD_ARM    = 2'd1;
  localparam logic [1:0] CMD_DISARM = 2'd2;
  localparam logic [1:0] CMD_TICK   = 2'd3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_PATTERN = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_LENGTH  = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_OFFSET  = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_PULSE   = IDX_W'(3);

  typedef struct packed {
    logic match;
    logic tick;
  } fire_ctrl_t;

  typedef struct packed {
    logic idle;
    logic pulse_next;
  } fire_stat_t;

endpackage

/* design/spt_cell.sv */
// ----------------------------------------------------------------------------
// spt_cell
// One window byte: holds it, passes it on when shifting, compares the
// incoming byte against its pattern byte.
// ----------------------------------------------------------------------------
module spt_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic [7:0] byte_i,
  input  logic       en_i,
  input  logic [7:0] want_i,
  output logic [7:0] byte_o,
  output logic       hit_o
);

  logic [7:0] byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  // compare the value the cell takes on this shift
  assign hit_o  = !en_i || (byte_i == want_i);
  assign byte_o = byte_q;

endmodule

/* design/spt_fire.sv */
// ----------------------------------------------------------------------------
// spt_fire
// Firing sequencer: offset wait, then trigger pulse, both counted in ticks.
// ----------------------------------------------------------------------------
module spt_fire (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  spt_pkg::fire_ctrl_t       ctrl_i,
  input  logic [spt_pkg::TICK_W-1:0] offset_i,
  input  logic [spt_pkg::TICK_W-1:0] pulse_i,
  output spt_pkg::fire_stat_t       stat_o
);
  import spt_pkg::*;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_OFFSET = 2'd1;
  localparam logic [1:0] PH_PULSE  = 2'd2;

  logic [1:0]        phase_q, phase_d;
  logic [TICK_W-1:0] cnt_q, cnt_d;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    if (ctrl_i.match) begin
      if (offset_i == '0) begin
        phase_d = PH_PULSE;
        cnt_d   = pulse_i;
      end else begin
        phase_d = PH_OFFSET;
        cnt_d   = offset_i;
      end
    end else if (ctrl_i.tick) begin
      unique case (phase_q)
        PH_OFFSET: begin
          if (cnt_q <= TICK_W'(1)) begin
            phase_d = PH_PULSE;
            cnt_d   = pulse_i;
          end else begin
            cnt_d = cnt_q - TICK_W'(1);
          end
        end
        PH_PULSE: begin
          if (cnt_q <= TICK_W'(1)) begin
            phase_d = PH_IDLE;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q - TICK_W'(1);
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  assign stat_o.idle       = (phase_q == PH_IDLE);
  assign stat_o.pulse_next = (phase_d == PH_PULSE);

endmodule

/* design/serial_pattern_trigger.sv */
// ----------------------------------------------------------------------------
// serial_pattern_trigger
// Byte pattern match over a sliding window of cells, with a timed trigger.
// ----------------------------------------------------------------------------
// result: in the output register in the cycle after the input transaction
// throughput: one transaction per cycle while out_ready_i is high; the window cells compare in parallel
// and a new transaction enters in the cycle the waiting result is taken
// reset: window cleared, disarmed, firing idle, pulse_ticks 200, other config zero; result register not reset
module serial_pattern_trigger #(
  parameter int unsigned MAX_PATTERN = spt_pkg::MAX_PATTERN_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     command_i,
  input  logic [7:0]                     data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           armed_o,
  output logic                           matched_o,
  output logic                           trigger_level_o,
  output logic                           accepted_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [spt_pkg::IDX_W-1:0]      cfg_index_i,
  input  logic [8*spt_pkg::PAT_BYTES-1:0] cfg_data_i
);
  import spt_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

  logic [8*PAT_BYTES-1:0] pat_q;
  logic [LEN_W-1:0]       len_q;
  logic [TICK_W-1:0]      offset_q;
  logic [TICK_W-1:0]      pulse_q;

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q    <= '0;
      len_q    <= '0;
      offset_q <= '0;
      pulse_q  <= PULSE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PATTERN: pat_q    <= cfg_data_i;
        REG_LENGTH:  len_q    <= cfg_data_i[LEN_W-1:0];
        REG_OFFSET:  offset_q <= cfg_data_i[TICK_W-1:0];
        REG_PULSE:   pulse_q  <= cfg_data_i[TICK_W-1:0];
        default: begin
          pat_q <= pat_q;
        end
      endcase
    end
  end

  logic       in_acc;
  logic       armed_q, armed_d;
  logic       shift;
  logic       match;
  logic       accepted;
  logic [LEN_W-1:0] used_len;
  logic [7:0] win  [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hits;
  fire_ctrl_t fctrl;
  fire_stat_t fstat;
  logic       out_valid_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign shift      = in_acc && (command_i == CMD_BYTE) && armed_q;
  assign used_len   = (len_q > MAX_LEN) ? MAX_LEN : len_q;

  // window: cell MAX_PATTERN-1 takes the new byte, the rest take their neighbor
  for (genvar pos = 0; pos < MAX_PATTERN; pos++) begin : g_cell
    logic [LEN_W:0] sum;
    logic [LEN_W:0] k;
    logic           en;
    logic [7:0]     nb;

    assign sum = (LEN_W+1)'(pos) + {1'b0, used_len};
    assign en  = (sum >= (LEN_W+1)'(MAX_PATTERN));
    assign k   = sum - (LEN_W+1)'(MAX_PATTERN);

    if (pos == MAX_PATTERN - 1) begin : g_last
      assign nb = data_i;
    end else begin : g_mid
      assign nb = win[pos+1];
    end

    spt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .byte_i  (nb),
      .en_i    (en),
      .want_i  (pat_q[{k[2:0], 3'b000} +: 8]),
      .byte_o  (win[pos]),
      .hit_o   (hits[pos])
    );
  end

  assign match = shift && (used_len != '0) && (&hits);

  always_comb begin
    armed_d  = armed_q;
    accepted = 1'b0;
    if (in_acc) begin
      unique case (command_i)
        CMD_BYTE: begin
          if (match) begin
            armed_d = 1'b0;
          end
        end
        CMD_ARM: begin
          if (len_q != '0 && fstat.idle) begin
            armed_d  = 1'b1;
            accepted = 1'b1;
          end
        end
        CMD_DISARM: begin
          armed_d = 1'b0;
        end
        CMD_TICK: begin
          armed_d = armed_q;
        end
        default: begin
          armed_d = armed_q;
        end
      endcase
    end
  end

  assign fctrl.match = match;
  assign fctrl.tick  = in_acc && (command_i == CMD_TICK);

  spt_fire u_fire (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (fctrl),
    .offset_i (offset_q),
    .pulse_i  (pulse_q),
    .stat_o   (fstat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      armed_q <= armed_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      armed_o         <= armed_d;
      matched_o       <= match;
      trigger_level_o <= fstat.pulse_next;
      accepted_o      <= accepted;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // watching the traffic and firing never overlap
  a_armed_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> fstat.idle)
    else $error("armed while firing in progress");

  a_match_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && matched_o) |-> !armed_o)
    else $error("match result still armed");

  a_accept_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && accepted_o) |-> armed_o)
    else $error("accepted arm without armed flag");

  a_match_fires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match |=> !fstat.idle)
    else $error("match did not start firing");
`endif

endmodule
